// File: sv/stbe_pkg.sv
// Shared types, constants and the quarter-wave sine builder for the tone burst block.
// Used by stbe_env_div and sine_tone_burst_envelope; depends on nothing else.
`timescale 1ns / 1ps

package stbe_pkg;

    localparam int INDEX_WIDTH_DEF = 24;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int PHASE_WIDTH    = 32;
    localparam int AMP_WIDTH      = 15;
    localparam int COUNT_WIDTH    = 24;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int SINE_WIDTH     = 15;
    localparam int CFG_ADDR_WIDTH = 8;
    localparam int CFG_DATA_WIDTH = 32;

    // Envelope is unsigned Q1.16 with unity at 2^16
    localparam int ENV_FRAC_BITS = 16;
    localparam int ENV_WIDTH     = ENV_FRAC_BITS + 1;
    localparam int DIV_STEPS     = ENV_FRAC_BITS + 1;
    localparam logic [ENV_WIDTH-1:0] ENV_ONE = ENV_WIDTH'(1) << ENV_FRAC_BITS;

    // env * amplitude * sine is scaled down by 2^31
    localparam int PRODUCT_SHIFT = 31;

    localparam logic [AMP_WIDTH-1:0] AMP_RESET = AMP_WIDTH'(16384);

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Configuration register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PHASE_STEP      = CFG_ADDR_WIDTH'(0);
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MAX_AMPLITUDE   = CFG_ADDR_WIDTH'(1);
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_ATTACK_SAMPLES  = CFG_ADDR_WIDTH'(2);
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RELEASE_SAMPLES = CFG_ADDR_WIDTH'(3);

    typedef struct packed {
        logic valid;
        logic unity;
    } div_ctl_t;

    typedef struct packed {
        logic                  neg;
        logic [SINE_WIDTH-1:0] mag;
    } sine_t;

    // Q30 Taylor series of sin(x) up to x^17, rounded to Q1.15 magnitude.
    // Evaluated at elaboration only.
    function automatic logic [SINE_WIDTH-1:0] quarter_sine(input longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >>> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 156;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 210;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 272;
        sum  = sum + term;
        if (sum < 0)
            sum = 0;
        if (sum > Q30_ONE)
            sum = Q30_ONE;
        return SINE_WIDTH'((sum * 32767 + (Q30_ONE / 2)) >>> 30);
    endfunction

endpackage

// File: sv/stbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the quarter-wave sine table.
`timescale 1ns / 1ps

module stbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/stbe_env_div.sv
// Pipelined restoring divider for the envelope: floor(num * 2^16 / den), num <= den.
// One quotient bit per stage; carries the sine sample alongside. Depends on stbe_pkg.
`timescale 1ns / 1ps

module stbe_env_div #(
    parameter int NUM_WIDTH = stbe_pkg::INDEX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  stbe_pkg::div_ctl_t               ctl_in,
    input  logic [NUM_WIDTH-1:0]             num,
    input  logic [NUM_WIDTH-1:0]             den,
    input  stbe_pkg::sine_t                  side_in,
    output stbe_pkg::div_ctl_t               ctl_out,
    output logic [stbe_pkg::ENV_WIDTH-1:0]   env,
    output stbe_pkg::sine_t                  side_out
);

    localparam int STEPS = stbe_pkg::DIV_STEPS;
    localparam int QW    = stbe_pkg::ENV_WIDTH;

    stbe_pkg::div_ctl_t   ctl_reg  [STEPS];
    stbe_pkg::sine_t      side_reg [STEPS];
    logic [NUM_WIDTH-1:0] rem_reg  [STEPS];
    logic [NUM_WIDTH-1:0] den_reg  [STEPS];
    logic [QW-1:0]        q_reg    [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        stbe_pkg::div_ctl_t   ctl_k;
        stbe_pkg::sine_t      side_k;
        logic [NUM_WIDTH-1:0] den_k;
        logic [QW-1:0]        q_k;
        logic [NUM_WIDTH:0]   trial;
        logic                 ge;

        if (k == 0)
        begin : g_first
            // Top quotient bit: set only when num equals den
            assign ctl_k  = ctl_in;
            assign side_k = side_in;
            assign den_k  = den;
            assign q_k    = '0;
            assign trial  = {1'b0, num};
        end
        else
        begin : g_next
            assign ctl_k  = ctl_reg[k-1];
            assign side_k = side_reg[k-1];
            assign den_k  = den_reg[k-1];
            assign q_k    = q_reg[k-1];
            assign trial  = {rem_reg[k-1], 1'b0};
        end

        assign ge = (trial >= {1'b0, den_k});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_k;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_k;
                den_reg[k]  <= den_k;
                q_reg[k]    <= {q_k[QW-2:0], ge};
                rem_reg[k]  <= ge ? NUM_WIDTH'(trial - {1'b0, den_k}) : NUM_WIDTH'(trial);
            end
        end
    end

    assign ctl_out  = ctl_reg[STEPS-1];
    assign side_out = side_reg[STEPS-1];
    assign env      = ctl_reg[STEPS-1].unity ? stbe_pkg::ENV_ONE : q_reg[STEPS-1];

endmodule

// File: sv/sine_tone_burst_envelope.sv
// Top level of the sine tone burst generator: phase, sine table, envelope and product.
// Depends on stbe_pkg, stbe_ram and stbe_env_div.
`timescale 1ns / 1ps

// Usage
//   s_* : one transfer per sample request; s_tdata = {total_samples, sample_index}.
//   m_* : one transfer per result; m_tdata = signed 16-bit PCM sample.
//   cfg : register writes (index in cfg_addr, value in cfg_data), always ready.
//         Write only while no request is in flight.
// Throughput: one sample per clock cycle while the output is not stalled, fully pipelined.
// Pipeline: input capture, phase multiplier, table index and sine RAM read,
//   then the one-bit-per-stage envelope divider, then the two product
//   multipliers and the output register.
// Reset: control and configuration registers return to their reset values
//   and the sine table RAM is loaded with all SINE_TABLE_DEPTH + 1 entries
//   (1025 by default); s_tready stays low until it is done.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds;
//   s_tready drops in the same cycle, so nothing is lost or repeated.
module sine_tone_burst_envelope #(
    parameter int INDEX_WIDTH      = stbe_pkg::INDEX_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = stbe_pkg::SINE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample_index, total_samples, zero padding to bytes
    input  logic [((2*INDEX_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sample
    output logic [stbe_pkg::SAMPLE_WIDTH-1:0]    m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [stbe_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [stbe_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int W       = INDEX_WIDTH;
    localparam int TAB_N   = SINE_TABLE_DEPTH + 1;
    localparam int ADDR_W  = $clog2(TAB_N);
    localparam int JPROD_W = 30 + ADDR_W;
    localparam int PW      = stbe_pkg::PHASE_WIDTH;
    localparam int SW      = stbe_pkg::SINE_WIDTH;
    localparam int P1_W    = stbe_pkg::ENV_WIDTH + stbe_pkg::AMP_WIDTH;
    localparam int P2_W    = P1_W + SW;
    localparam int OUT_W   = stbe_pkg::SAMPLE_WIDTH;

    // ---------------- configuration registers ----------------
    logic [PW-1:0]                    phase_step_reg;
    logic [stbe_pkg::AMP_WIDTH-1:0]   amp_reg;
    logic [stbe_pkg::COUNT_WIDTH-1:0] attack_reg;
    logic [stbe_pkg::COUNT_WIDTH-1:0] release_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            amp_reg        <= stbe_pkg::AMP_RESET;
            attack_reg     <= '0;
            release_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                stbe_pkg::REG_PHASE_STEP:      phase_step_reg <= cfg_data[PW-1:0];
                stbe_pkg::REG_MAX_AMPLITUDE:   amp_reg <= cfg_data[stbe_pkg::AMP_WIDTH-1:0];
                stbe_pkg::REG_ATTACK_SAMPLES:  attack_reg <= cfg_data[stbe_pkg::COUNT_WIDTH-1:0];
                stbe_pkg::REG_RELEASE_SAMPLES: release_reg <= cfg_data[stbe_pkg::COUNT_WIDTH-1:0];
                default:                       ;
            endcase
        end
    end

    logic [W-1:0] attack_w;
    logic [W-1:0] release_w;
    assign attack_w  = W'(attack_reg);
    assign release_w = W'(release_reg);

    // ---------------- sine table load after reset ----------------
    logic [SW-1:0] sine_const [TAB_N];

    for (genvar k = 0; k < TAB_N; k++)
    begin : g_sine
        localparam longint X = stbe_pkg::HALF_PI_Q30 * longint'(k) / SINE_TABLE_DEPTH;
        localparam logic [SW-1:0] ENTRY = stbe_pkg::quarter_sine(X);
        assign sine_const[k] = ENTRY;
    end

    logic [ADDR_W-1:0] fill_cnt_reg;
    logic              fill_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            fill_done_reg <= 1'b0;
        end
        else if (!fill_done_reg)
        begin
            if (fill_cnt_reg == ADDR_W'(SINE_TABLE_DEPTH))
            begin
                fill_done_reg <= 1'b1;
            end
            else
            begin
                fill_cnt_reg <= fill_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic out_valid_reg;
    logic stage_en;
    logic in_xfer;

    assign stage_en = !out_valid_reg || m_tready;
    assign s_tready = stage_en && fill_done_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // ---------------- stage 1: capture ----------------
    logic         s1_valid_reg;
    logic [W-1:0] s1_i_reg;
    logic [W-1:0] s1_n_reg;

    // ---------------- stage 2: phase and envelope compares ----------------
    logic          s2_valid_reg;
    logic [PW-1:0] s2_phase_reg;
    logic          s2_att_reg;
    logic          s2_rel_reg;
    logic [W-1:0]  s2_i_reg;
    logic [W-1:0]  s2_relnum_reg;

    logic [W+PW-1:0] phase_full;
    logic [W:0]      i_plus_r;
    logic            att_hit;
    logic            rel_hit;
    logic [W-1:0]    rel_num;

    assign phase_full = (W+PW)'(s1_i_reg) * (W+PW)'(phase_step_reg);
    assign i_plus_r   = {1'b0, s1_i_reg} + {1'b0, release_w};
    assign att_hit    = (attack_w != '0) && (s1_i_reg < attack_w);
    assign rel_hit    = (release_w != '0) && (i_plus_r >= {1'b0, s1_n_reg});
    // Clamp to zero past the end of the burst
    assign rel_num    = (s1_n_reg > s1_i_reg) ? (s1_n_reg - s1_i_reg) : '0;

    // ---------------- stage 3: table index, divider operands ----------------
    logic              s3_valid_reg;
    logic [1:0]        s3_quad_reg;
    logic [ADDR_W-1:0] s3_j_reg;
    logic [W-1:0]      s3_num_reg;
    logic [W-1:0]      s3_den_reg;
    logic              s3_unity_reg;

    logic [JPROD_W-1:0] jprod;
    assign jprod = JPROD_W'(s2_phase_reg[29:0]) * JPROD_W'(SINE_TABLE_DEPTH);

    // ---------------- stage 4: sine RAM read ----------------
    logic              s4_valid_reg;
    logic [W-1:0]      s4_num_reg;
    logic [W-1:0]      s4_den_reg;
    logic              s4_unity_reg;
    logic              s4_neg_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [SW-1:0]     sine_mag;

    // Odd quadrants read the table mirrored
    assign rd_addr = s3_quad_reg[0] ? (ADDR_W'(SINE_TABLE_DEPTH) - s3_j_reg) : s3_j_reg;

    stbe_ram #(
        .WIDTH (SW),
        .DEPTH (TAB_N)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (!fill_done_reg),
        .wr_addr (fill_cnt_reg),
        .wr_data (sine_const[fill_cnt_reg]),
        .rd_en   (stage_en),
        .rd_addr (rd_addr),
        .rd_data (sine_mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (stage_en)
        begin
            s1_valid_reg <= in_xfer;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            s1_i_reg      <= s_tdata[W-1:0];
            s1_n_reg      <= s_tdata[2*W-1:W];

            s2_phase_reg  <= phase_full[PW-1:0];
            s2_att_reg    <= att_hit;
            s2_rel_reg    <= rel_hit;
            s2_i_reg      <= s1_i_reg;
            s2_relnum_reg <= rel_num;

            s3_quad_reg   <= s2_phase_reg[PW-1:PW-2];
            s3_j_reg      <= jprod[JPROD_W-1:30];
            s3_num_reg    <= s2_att_reg ? s2_i_reg : s2_relnum_reg;
            s3_den_reg    <= s2_att_reg ? attack_w : release_w;
            s3_unity_reg  <= !s2_att_reg && !s2_rel_reg;

            s4_num_reg    <= s3_num_reg;
            s4_den_reg    <= s3_den_reg;
            s4_unity_reg  <= s3_unity_reg;
            s4_neg_reg    <= s3_quad_reg[1];
        end
    end

    // ---------------- envelope divider ----------------
    stbe_pkg::div_ctl_t             div_ctl_in;
    stbe_pkg::div_ctl_t             div_ctl_out;
    stbe_pkg::sine_t                div_side_in;
    stbe_pkg::sine_t                div_side_out;
    logic [stbe_pkg::ENV_WIDTH-1:0] div_env;

    assign div_ctl_in.valid = s4_valid_reg;
    assign div_ctl_in.unity = s4_unity_reg;
    assign div_side_in.neg  = s4_neg_reg;
    assign div_side_in.mag  = sine_mag;

    stbe_env_div #(
        .NUM_WIDTH (W)
    ) u_env_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (stage_en),
        .ctl_in   (div_ctl_in),
        .num      (s4_num_reg),
        .den      (s4_den_reg),
        .side_in  (div_side_in),
        .ctl_out  (div_ctl_out),
        .env      (div_env),
        .side_out (div_side_out)
    );

    // ---------------- products and output ----------------
    logic            m1_valid_reg;
    logic [P1_W-1:0] m1_prod_reg;
    logic [SW-1:0]   m1_mag_reg;
    logic            m1_neg_reg;

    logic            m2_valid_reg;
    logic [SW-1:0]   m2_mag_reg;
    logic            m2_neg_reg;

    logic [OUT_W-1:0] sample_reg;
    logic [OUT_W-1:0] sample_next;
    logic [P2_W-1:0]  prod2;

    assign prod2 = P2_W'(m1_prod_reg) * P2_W'(m1_mag_reg);

    // Magnitude stays below 32767, so the result never needs saturation
    assign sample_next = m2_neg_reg ? (OUT_W'(0) - {1'b0, m2_mag_reg}) : {1'b0, m2_mag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (stage_en)
        begin
            m1_valid_reg  <= div_ctl_out.valid;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            m1_prod_reg <= P1_W'(div_env) * P1_W'(amp_reg);
            m1_mag_reg  <= div_side_out.mag;
            m1_neg_reg  <= div_side_out.neg;
            m2_mag_reg  <= prod2[stbe_pkg::PRODUCT_SHIFT +: SW];
            m2_neg_reg  <= m1_neg_reg;
            sample_reg  <= sample_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sample_reg;

    // ---------------- assertions ----------------
    a_fill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fill_done_reg |=> fill_done_reg)
        else $error("sine table load restarted");

    a_no_work_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !fill_done_reg |-> (!s1_valid_reg && !s4_valid_reg && !div_ctl_out.valid))
        else $error("item in flight before sine table load finished");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_en |=> ($stable(s4_valid_reg) && $stable(m2_valid_reg)
                       && $stable(div_ctl_out.valid)))
        else $error("pipeline moved during output stall");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg != {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("sample magnitude overflow");

endmodule

// File: dv/sine_tone_burst_envelope_test.sv
// Self-checking testbench for sine_tone_burst_envelope: enveloped sine samples over stream ports.
// Depends on stbe_pkg and the block's RTL; predicts each sample from its own table and registers.
`timescale 1ns / 1ps

module sine_tone_burst_envelope_test;

    localparam int IDX_W       = stbe_pkg::INDEX_WIDTH_DEF;
    localparam int SINE_DEPTH  = stbe_pkg::SINE_DEPTH_DEF;
    localparam int TDATA_W     = ((2*IDX_W+7)/8)*8;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int ITEMS_PER_SETTING = 100;
    localparam int AW = stbe_pkg::CFG_ADDR_WIDTH;
    localparam int DW = stbe_pkg::CFG_DATA_WIDTH;
    localparam int SMP_W = stbe_pkg::SAMPLE_WIDTH;

    // indexes outside the register map, writes must be dropped
    localparam logic [AW-1:0] REG_SPARE = AW'(4);
    localparam logic [AW-1:0] REG_TOP   = AW'(255);

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] total;
        logic [SMP_W-1:0] pcm;
    } tone_expect_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [SMP_W-1:0]   m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [AW-1:0]      cfg_addr = '0;
    logic [DW-1:0]      cfg_data = '0;

    // register copies used for prediction
    logic [stbe_pkg::PHASE_WIDTH-1:0] step_q    = '0;
    logic [stbe_pkg::AMP_WIDTH-1:0]   amp_q     = stbe_pkg::AMP_RESET;
    logic [IDX_W-1:0]                 attack_q  = '0;
    logic [IDX_W-1:0]                 release_q = '0;

    int           sine_rom [0:SINE_DEPTH];
    tone_expect_t pcm_expected [$];
    tone_expect_t pcm_head;
    int           mismatch_count = 0;
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    int unsigned  cycle_count = 0;

    sine_tone_burst_envelope u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sine_tone_burst_envelope: mismatch");
        $finish;
    end

    // Quarter-wave table: Q30 Taylor series to x^17, rounded to Q1.15
    initial
    begin : build_quarter_wave
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            x    = stbe_pkg::HALF_PI_Q30 * k / SINE_DEPTH;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
                sum  = (n % 2 == 1) ? sum - term : sum + term;
            end
            if (sum < 0)
                sum = 0;
            if (sum > stbe_pkg::Q30_ONE)
                sum = stbe_pkg::Q30_ONE;
            sine_rom[k] = int'((sum * 32767 + stbe_pkg::Q30_ONE / 2) >>> 30);
        end
    end

    function automatic logic [SMP_W-1:0] predict_pcm(input logic [IDX_W-1:0] idx,
                                                     input logic [IDX_W-1:0] total);
        logic [63:0]                      turn;
        logic [stbe_pkg::PHASE_WIDTH-1:0] phase;
        longint                           j;
        longint                           tab;
        longint                           env;
        longint                           mag;
        longint                           val;
        turn  = 64'(idx) * 64'(step_q);
        phase = turn[stbe_pkg::PHASE_WIDTH-1:0];
        j     = (longint'(phase[29:0]) * SINE_DEPTH) >>> 30;
        tab   = phase[30] ? sine_rom[SINE_DEPTH - j] : sine_rom[j];
        // attack takes priority over release where both apply
        if (attack_q != 0 && idx < attack_q)
            env = (longint'(idx) << stbe_pkg::ENV_FRAC_BITS) / longint'(attack_q);
        else if (release_q != 0 && longint'(idx) + longint'(release_q) >= longint'(total))
            env = (total > idx) ?
                  ((longint'(total) - longint'(idx)) << stbe_pkg::ENV_FRAC_BITS)
                  / longint'(release_q) : 0;
        else
            env = longint'(stbe_pkg::ENV_ONE);
        mag = (env * longint'(amp_q) * tab) >>> stbe_pkg::PRODUCT_SHIFT;
        val = phase[31] ? -mag : mag;
        if (val > 32767)
            val = 32767;
        if (val < -32768)
            val = -32768;
        return SMP_W'(val);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Sink side: random backpressure and compare every output transfer in order
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pcm_expected.size() == 0)
                report_mismatch($sformatf("sample %0d with none pending", $signed(m_tdata)));
            else
            begin
                pcm_head = pcm_expected.pop_front();
                if (m_tdata !== pcm_head.pcm)
                    report_mismatch($sformatf("index %0d total %0d: sample %0d, want %0d",
                        pcm_head.idx, pcm_head.total, $signed(m_tdata),
                        $signed(pcm_head.pcm)));
            end
        end
    end

    task automatic send_request(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] total);
        tone_expect_t item;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({total, idx});
        do
            @(posedge clk);
        while (!s_tready);
        item.idx   = idx;
        item.total = total;
        item.pcm   = predict_pcm(idx, total);
        pcm_expected.push_back(item);
    endtask

    // Hold the source until every pending sample is out and the pipeline is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pcm_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [AW-1:0] addr, input logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (addr)
            stbe_pkg::REG_PHASE_STEP:      step_q    = data;
            stbe_pkg::REG_MAX_AMPLITUDE:   amp_q     = data[stbe_pkg::AMP_WIDTH-1:0];
            stbe_pkg::REG_ATTACK_SAMPLES:  attack_q  = data[IDX_W-1:0];
            stbe_pkg::REG_RELEASE_SAMPLES: release_q = data[IDX_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_tone(input logic [31:0] step, input logic [31:0] amp,
                            input logic [31:0] attack, input logic [31:0] rel);
        wait_drained();
        write_reg(stbe_pkg::REG_PHASE_STEP, step);
        write_reg(stbe_pkg::REG_MAX_AMPLITUDE, amp);
        write_reg(stbe_pkg::REG_ATTACK_SAMPLES, attack);
        write_reg(stbe_pkg::REG_RELEASE_SAMPLES, rel);
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return $urandom_range(1, 4);
            2: return $urandom_range(1, 40);
            default: return $urandom & 32'hFF_FFFF;
        endcase
    endfunction

    task automatic test_reset_state();
        // zero phase step after reset: every sample is silent
        send_request('0, '0);
        send_request({IDX_W{1'b1}}, 24'd100);
    endtask

    task automatic test_quadrants();
        set_tone(32'h4000_0000, 32'h7FFF, 0, 0);
        send_request(24'd0, 24'd8);
        send_request(24'd1, 24'd8);
        send_request(24'd2, 24'd8);
        send_request(24'd3, 24'd8);
        // past the end with release off keeps full level
        send_request(24'd5, 24'd2);
        send_request(24'hFF_FFFF, 24'hFF_FFFF);
        set_tone(32'hFFFF_FFFF, 32'h7FFF, 0, 0);
        send_request(24'd1, 24'd4);
        send_request(24'hFF_FFFF, 24'd0);
    endtask

    task automatic test_envelope_edges();
        // quarter-turn step: indexes 1 mod 4 sit on the positive peak
        set_tone(32'h4000_0000, 32'h7FFF, 8, 8);
        send_request(24'd1, 24'd20);
        send_request(24'd5, 24'd20);
        send_request(24'd9, 24'd20);
        send_request(24'd13, 24'd20);
        send_request(24'd13, 24'd21);
        send_request(24'd17, 24'd20);
        send_request(24'd21, 24'd20);
        send_request(24'd5, 24'd10);
        send_request(24'd1, 24'd0);
        set_tone(32'h4000_0000, 32'h7FFF, 32'hFF_FFFF, 32'hFF_FFFF);
        send_request(24'hFF_FFFD, 24'hFF_FFFF);
        send_request(24'd1, 24'd2);
    endtask

    task automatic test_register_masking();
        wait_drained();
        write_reg(stbe_pkg::REG_MAX_AMPLITUDE, 32'd0);
        send_request(24'd1, 24'd9);
        wait_drained();
        write_reg(stbe_pkg::REG_MAX_AMPLITUDE, 32'hFFFF_FFFF);
        write_reg(stbe_pkg::REG_ATTACK_SAMPLES, 32'hFF00_0004);
        write_reg(stbe_pkg::REG_RELEASE_SAMPLES, 32'hAB00_0000);
        write_reg(REG_SPARE, 32'h1234_5678);
        write_reg(REG_TOP, 32'hFFFF_FFFF);
        send_request(24'd1, 24'd9);
        send_request(24'd5, 24'd9);
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct);
        int     sent;
        int     kind;
        bit     paused;
        longint burst_len;
        longint first;
        longint back;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int setting = 0; setting < 3; setting++)
        begin
            set_tone($urandom, ($urandom_range(2) == 0) ? 32'h7FFF : $urandom_range(32767),
                     pick_count(), pick_count());
            sent   = 0;
            paused = 1'b0;
            while (sent < ITEMS_PER_SETTING)
            begin
                kind = $urandom_range(9);
                if (kind < 8)
                begin
                    if (kind < 6)
                    begin
                        burst_len = $urandom_range(80);
                        first     = 0;
                    end
                    else
                    begin
                        // tail of a long burst, running a little past its end
                        burst_len = $urandom & 32'hFF_FFFF;
                        back      = $urandom_range(40);
                        first     = (burst_len > back) ? burst_len - back : 0;
                    end
                    for (longint i = first; i <= burst_len + 1 && sent < ITEMS_PER_SETTING; i++)
                    begin
                        send_request(IDX_W'(i), IDX_W'(burst_len));
                        sent++;
                    end
                end
                else
                begin
                    send_request(IDX_W'($urandom), IDX_W'($urandom));
                    sent++;
                end
                if (!paused && sent >= ITEMS_PER_SETTING / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end
    endtask

    task automatic test_random_bursts();
        run_random_phase(0, 0);
        run_random_phase(65, 0);
        run_random_phase(0, 65);
        run_random_phase(30, 30);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_quadrants();
        test_envelope_edges();
        test_register_masking();
        test_random_bursts();
        wait_drained();
        if (mismatch_count == 0)
            $display("sine_tone_burst_envelope: match");
        else
            $display("sine_tone_burst_envelope: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
sv/stbe_pkg.sv
sv/stbe_ram.sv
sv/stbe_env_div.sv
sv/sine_tone_burst_envelope.sv
dv/sine_tone_burst_envelope_test.sv
